[src/radix_tree_table_macros.svh]
// assertion macros for the radix tree table
// no dependencies; included by files that carry concurrent assertions
`ifndef RADIX_TREE_TABLE_MACROS_SVH
`define RADIX_TREE_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rtt_pkg.sv]
// shared constants, codes and controller/datapath interface types
// for the radix tree table; no dependencies
package rtt_pkg;

  localparam int FANOUT      = 16;
  localparam int LOG2_FANOUT = 4;
  localparam int KEY_W       = 28;
  localparam int VAL_W       = 32;

  localparam logic [2:0] MAX_LEVELS = 3'd7;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // write one zero entry of the clearing pass
    logic latch;     // capture the input transaction
    logic chk;       // screen the request, set up the walk
    logic rd;        // read the node entry of the current level
    logic eval;      // act on the entry just read
    logic load_out;  // move the result into the output register
  } rtt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at its last entry
    logic chk_stop;   // request ends at screening
    logic walk_stop;  // walk ends at this level
  } rtt_stat_t;

endpackage

[src/radix_tree_table.sv]
// Radix tree table: sparse key-to-value map kept as a fixed-depth 16-ary tree.
// Channels: in_* carries one request per transaction (operation, key, value),
// out_* returns one result per request (value_out, status), both valid/ready.
// cfg_* writes the levels register (1..7); writes are taken at any time and
// belong in idle periods only, cfg_ready is always high.
// A walk over L levels reads one node entry per level through the single
// store read port, a read step and then an act step per level; after acceptance
// a request passes screening, the walk and a done step that loads the output
// register; screened-out requests (range, zero value, no-op) skip the walk
// and walks that stop early skip the remaining levels.
// One request is in flight at a time; in_ready returns once the result sits
// in the output register, so a new request can be taken while out_valid waits.
// If the receiver stalls with a result still held, the next result waits in
// the datapath result registers, with the controller holding in its done step, until the output register frees up.
// Reset: synchronous, active low. The node store is then zeroed by a sweep
// over all NODE_POOL*16 entries (4096 by default) during which in_ready stays low;
// the allocator restarts at node 1 and levels returns to 1.
// Depends on rtt_pkg, rtt_ctrl, rtt_datapath and radix_tree_table_macros.svh.
`include "radix_tree_table_macros.svh"

module radix_tree_table #(
  parameter int NODE_POOL = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_levels,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_operation,
  input  logic [rtt_pkg::KEY_W-1:0] in_key,
  input  logic [rtt_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rtt_pkg::VAL_W-1:0] out_value_out,
  output logic [1:0]                out_status
);
  import rtt_pkg::*;

  rtt_cmd_t  cmd;
  rtt_stat_t stat;

  // levels register takes every write transaction
  assign cfg_ready = 1'b1;

  // sequencer: clearing pass, screening, per-level read/act steps, handoff
  rtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // node store, bump allocator, walk registers, result register
  rtt_datapath #(
    .NODE_POOL (NODE_POOL)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_levels    (cfg_levels),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_value_out (out_value_out),
    .out_status    (out_status)
  );

  // no request is taken while the store is still being cleared
  `RTT_ASSERT_NOW(a_no_accept_in_clear, in_ready, !cmd.clr_step, "request accepted during clear")

  // one request in flight: accepting closes the request channel next cycle
  `RTT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken")

  // any error status carries a zero value
  `RTT_ASSERT_NOW(a_err_zero_value, out_valid && (out_status != ST_OK), out_value_out == '0, "error result with nonzero value")

  // a result is loaded only after a walk step or screening, never straight from idle
  `RTT_ASSERT_NEXT(a_load_after_work, in_valid && in_ready, !cmd.load_out, "result loaded without work")

endmodule

[src/rtt_ctrl.sv]
// controller state machine for the radix tree table
// depends on rtt_pkg for the command and status types
module rtt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rtt_pkg::rtt_stat_t stat,
  output rtt_pkg::rtt_cmd_t  cmd
);
  import rtt_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.latch    = (state_r == S_IDLE) && in_valid;
    cmd.chk      = (state_r == S_CHECK);
    cmd.rd       = (state_r == S_READ);
    cmd.eval     = (state_r == S_EVAL);
    cmd.load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.chk_stop ? S_DONE : S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = stat.walk_stop ? S_DONE : S_READ;
      S_DONE:  if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/rtt_datapath.sv]
// datapath of the radix tree table: node store, allocator, walk registers,
// levels register and output register; depends on rtt_pkg
module rtt_datapath #(
  parameter int NODE_POOL = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtt_pkg::rtt_cmd_t         cmd,
  output rtt_pkg::rtt_stat_t        stat,
  input  logic                      cfg_valid,
  input  logic [2:0]                cfg_levels,
  input  logic [1:0]                in_operation,
  input  logic [rtt_pkg::KEY_W-1:0] in_key,
  input  logic [rtt_pkg::VAL_W-1:0] in_value,
  output logic [rtt_pkg::VAL_W-1:0] out_value_out,
  output logic [1:0]                out_status
);
  import rtt_pkg::*;

  localparam int NW    = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int NFW   = $clog2(NODE_POOL + 1);
  localparam int AW    = NW + LOG2_FANOUT;
  localparam int DEPTH = NODE_POOL * FANOUT;

  logic [VAL_W-1:0]       mem [DEPTH];
  logic [VAL_W-1:0]       rd_data_r;

  logic [1:0]             op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic [2:0]             levels_r;
  logic [NFW-1:0]         nfree_r, nfree_nxt;
  logic [AW-1:0]          clr_addr_r;
  logic [2:0]             lvl_r, lvl_nxt;
  logic [NW-1:0]          node_r, node_nxt;
  logic [VAL_W-1:0]       res_val_r, res_val_nxt;
  logic [1:0]             res_st_r, res_st_nxt;
  logic [VAL_W-1:0]       out_value_r;
  logic [1:0]             out_status_r;

  logic [2:0]             lv;
  logic [4:0]             shamt;
  logic                   range_err;
  logic                   zero_err;
  logic [2:0]             dsel;
  logic [LOG2_FANOUT-1:0] digit;
  logic [AW-1:0]          walk_addr;
  logic                   leaf;
  logic                   child_ok;
  logic                   pool_full;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VAL_W-1:0]       mem_wdata;

  // effective level count, out-of-range settings clamp
  always_comb begin
    if (levels_r == 3'd0) begin
      lv = 3'd1;
    end else if (levels_r > MAX_LEVELS) begin
      lv = MAX_LEVELS;
    end else begin
      lv = levels_r;
    end
  end

  assign shamt     = 5'(lv * LOG2_FANOUT);
  assign range_err = |(key_r >> shamt);
  assign zero_err  = (op_r == OP_INSERT) && (val_r == '0);

  assign dsel      = lvl_r - 3'd1;
  assign digit     = key_r[dsel * LOG2_FANOUT +: LOG2_FANOUT];
  assign walk_addr = {node_r, digit};

  assign leaf      = (lvl_r == 3'd1);
  assign child_ok  = (rd_data_r != '0) && (rd_data_r < VAL_W'(NODE_POOL));
  assign pool_full = (nfree_r >= NFW'(NODE_POOL));

  assign stat.clr_last  = (clr_addr_r == AW'(DEPTH - 1));
  assign stat.chk_stop  = (op_r == OP_NOP) || range_err || zero_err;
  assign stat.walk_stop = leaf || (!child_ok && ((op_r != OP_INSERT) || pool_full));

  // walk state and store write port
  always_comb begin
    lvl_nxt     = lvl_r;
    node_nxt    = node_r;
    nfree_nxt   = nfree_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    mem_we      = 1'b0;
    mem_waddr   = walk_addr;
    mem_wdata   = '0;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end
    if (cmd.chk) begin
      lvl_nxt     = lv;
      node_nxt    = '0;
      res_val_nxt = '0;
      priority if (op_r == OP_NOP) begin
        res_st_nxt = ST_OK;
      end else if (range_err) begin
        res_st_nxt = ST_RANGE;
      end else if (zero_err) begin
        res_st_nxt = ST_ZERO;
      end else begin
        res_st_nxt = ST_OK;
      end
    end
    if (cmd.eval) begin
      if (leaf) begin
        if (op_r == OP_GET) begin
          res_val_nxt = rd_data_r;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = (op_r == OP_INSERT) ? val_r : '0;
        end
      end else if (child_ok) begin
        node_nxt = rd_data_r[NW-1:0];
        lvl_nxt  = lvl_r - 3'd1;
      end else if (op_r == OP_INSERT) begin
        if (pool_full) begin
          res_st_nxt = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = VAL_W'(nfree_r);
          node_nxt  = nfree_r[NW-1:0];
          nfree_nxt = nfree_r + NFW'(1);
          lvl_nxt   = lvl_r - 3'd1;
        end
      end
    end
  end

  // node store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r   <= 3'd1;
      nfree_r    <= NFW'(1);
      clr_addr_r <= '0;
    end else begin
      if (cfg_valid) begin
        levels_r <= cfg_levels;
      end
      nfree_r <= nfree_nxt;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    lvl_r     <= lvl_nxt;
    node_r    <= node_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (cmd.load_out) begin
      out_value_r  <= res_val_r;
      out_status_r <= res_st_r;
    end
  end

  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

endmodule
